// ===== rtl/nbd_pkg.sv =====
// Shared types and constants of the direct-sum gravity block.
// No dependencies.
package nbd_pkg;

    localparam int MAX_PARTICLES_DEF = 64;
    localparam int POS_W = 16;
    localparam int IDX_W = 6;
    localparam int CNT_W = 7;
    localparam int ACC_W = 32;
    localparam int ENTRY_W = 3 * POS_W;
    localparam int DIFF_W = POS_W + 1;
    localparam int SQ_W = 2 * POS_W;
    localparam int R2_W = SQ_W + 2;
    localparam int WIDE_W = 64;
    localparam int T_W = 49;
    localparam int SQRT_STEPS = 32;
    localparam int MUL_STEPS = POS_W;
    localparam int SQRT_SHIFT = 28;
    localparam int RECIP_EXP = 62;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             ovf;
    } t_job;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_I,
        ST_WT_I,
        ST_RD_J,
        ST_WT_J,
        ST_SQ,
        ST_R2,
        ST_CHK,
        ST_SQRT,
        ST_DIV,
        ST_MUL,
        ST_ACC,
        ST_OUT
    } t_state;

endpackage

// ===== rtl/nbd_if.sv =====
// Valid/ready channel interfaces for positions in and accelerations out.
// Depends on nbd_pkg.
interface nbd_in_if;
    import nbd_pkg::*;
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] pos_z;
    logic             final_particle;
    modport source(output valid, pos_x, pos_y, pos_z, final_particle, input ready);
    modport sink(input valid, pos_x, pos_y, pos_z, final_particle, output ready);
endinterface

interface nbd_out_if;
    import nbd_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        particle_index;
    logic signed [ACC_W-1:0] accel_x;
    logic signed [ACC_W-1:0] accel_y;
    logic signed [ACC_W-1:0] accel_z;
    logic                    clipped;
    logic                    final_result;
    modport source(output valid, particle_index, accel_x, accel_y, accel_z, clipped,
                   final_result, input ready);
    modport sink(input valid, particle_index, accel_x, accel_y, accel_z, clipped,
                 final_result, output ready);
endinterface

// ===== rtl/nbody_direct_force_sum.sv =====
// Top level of the direct-sum gravity block: load side, job queue, compute side, store.
// Depends on nbd_pkg, nbd_if, nbd_ram, nbd_front, nbd_job_fifo, nbd_back.
//
// Usage: i_in carries one particle position (unsigned Q0.16 x, y, z) per word;
// final_particle marks the last of a set. Up to MAX_PARTICLES positions are stored;
// further words are dropped and flag every result of that set as clipped.
// After the final word, o_out gives one word per particle in load order with the
// Q16.16 acceleration sum, clipped flag and final_result on the last one.
// Compute: each particle pair runs a bit-serial square root of 32 steps, a
// 64-step shared divider run four times and a 16-step serial multiply per axis;
// a coincident pair skips these and only flags the result as clipped.
// Throughput of loading is one word per cycle; i_in.ready drops from the final
// word until the last result of that set is in the output register.
// When o_out is stalled the result holds; the next particle is computed and then
// waits for the output register.
// Reset (synchronous, active low) empties the store count, the queue and the output.
module nbody_direct_force_sum #(
    parameter int MAX_PARTICLES = nbd_pkg::MAX_PARTICLES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    nbd_in_if.sink     i_in,
    nbd_out_if.source  o_out
);
    import nbd_pkg::*;

    localparam int AW = $clog2(MAX_PARTICLES);

    logic               we;
    logic [AW-1:0]      waddr;
    logic [AW-1:0]      raddr;
    logic [ENTRY_W-1:0] wdata;
    logic [ENTRY_W-1:0] rdata;
    logic               push;
    t_job               job_in;
    t_job               job_out;
    logic               q_full;
    logic               q_valid;
    logic               pop;
    logic               done;

    nbd_front #(.MAX_PARTICLES(MAX_PARTICLES), .AW(AW)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(i_in),
        .o_we(we), .o_waddr(waddr), .o_wdata(wdata),
        .o_job_valid(push), .o_job(job_in), .i_job_ready(!q_full), .i_done(done)
    );

    nbd_job_fifo u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_job(job_in),
        .o_full(q_full), .o_valid(q_valid), .o_job(job_out), .i_pop(pop)
    );

    nbd_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_PARTICLES), .AW(AW)) u_store (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    nbd_back #(.MAX_PARTICLES(MAX_PARTICLES), .AW(AW)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job_valid(q_valid), .i_job(job_out),
        .o_job_pop(pop), .o_raddr(raddr), .i_rdata(rdata), .o_done(done), .o_out(o_out)
    );
endmodule

// ===== rtl/nbd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nbd_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64,
    parameter int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/nbd_front.sv =====
// Load side: takes positions, writes the store, counts and hands a job on the last one.
// Depends on nbd_pkg and nbd_if.
module nbd_front #(
    parameter int MAX_PARTICLES = nbd_pkg::MAX_PARTICLES_DEF,
    parameter int AW = $clog2(MAX_PARTICLES)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    nbd_in_if.sink                  i_in,
    output logic                    o_we,
    output logic [AW-1:0]           o_waddr,
    output logic [nbd_pkg::ENTRY_W-1:0] o_wdata,
    output logic                    o_job_valid,
    output nbd_pkg::t_job           o_job,
    input  logic                    i_job_ready,
    input  logic                    i_done
);
    import nbd_pkg::*;

    logic [CNT_W-1:0] r_count;
    logic             r_ovf;
    logic             r_lock;
    logic             acc;
    logic             full;
    logic [CNT_W-1:0] cnt_inc;
    logic             ovf_n;

    assign i_in.ready = !r_lock && i_job_ready;
    assign acc = i_in.valid && i_in.ready;
    assign full = (r_count == CNT_W'(MAX_PARTICLES));
    assign cnt_inc = full ? r_count : r_count + CNT_W'(1);
    assign ovf_n = r_ovf | full;

    assign o_we = acc && !full;
    assign o_waddr = r_count[AW-1:0];
    assign o_wdata = {i_in.pos_x, i_in.pos_y, i_in.pos_z};
    assign o_job_valid = acc && i_in.final_particle;
    assign o_job = '{count: cnt_inc, ovf: ovf_n};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf <= 1'b0;
            r_lock <= 1'b0;
        end else begin
            if (acc) begin
                if (i_in.final_particle) begin
                    r_count <= '0;
                    r_ovf <= 1'b0;
                    r_lock <= 1'b1;
                end else begin
                    r_count <= cnt_inc;
                    r_ovf <= ovf_n;
                end
            end else if (i_done) begin
                r_lock <= 1'b0;
            end
        end
    end
endmodule

// ===== rtl/nbd_job_fifo.sv =====
// Two-entry job queue between the load side and the compute side.
// Depends on nbd_pkg.
module nbd_job_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  nbd_pkg::t_job i_job,
    output logic          o_full,
    output logic          o_valid,
    output nbd_pkg::t_job o_job,
    input  logic          i_pop
);
    import nbd_pkg::*;

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_full = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end
endmodule

// ===== rtl/nbd_back.sv =====
// Compute side: per particle pair, squares, bit-serial root, shared divider, serial multiply.
// Depends on nbd_pkg and nbd_if.
module nbd_back #(
    parameter int MAX_PARTICLES = nbd_pkg::MAX_PARTICLES_DEF,
    parameter int AW = $clog2(MAX_PARTICLES)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_job_valid,
    input  nbd_pkg::t_job               i_job,
    output logic                        o_job_pop,
    output logic [AW-1:0]               o_raddr,
    input  logic [nbd_pkg::ENTRY_W-1:0] i_rdata,
    output logic                        o_done,
    nbd_out_if.source                   o_out
);
    import nbd_pkg::*;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_n, n_n, r_i, n_i, r_j, n_j;
    logic r_ovf, n_ovf;
    logic [1:0] r_k, n_k;
    logic [ENTRY_W-1:0] r_pi, n_pi;
    logic signed [DIFF_W-1:0] r_d [3], n_d [3];
    logic [SQ_W-1:0] r_sq [3], n_sq [3];
    logic [R2_W-1:0] r_r2, n_r2, r_den, n_den;
    logic [WIDE_W-1:0] r_srem, n_srem, r_res, n_res, r_num, n_num, r_prod, n_prod;
    logic [WIDE_W-1:0] r_mag, n_mag;
    logic [R2_W:0] r_drem, n_drem;
    logic [5:0] r_cnt, n_cnt;
    logic r_div_t, n_div_t;
    logic [T_W-1:0] r_t, n_t;
    logic signed [ACC_W-1:0] r_acc [3], n_acc [3];
    logic r_flag, n_flag;
    logic r_ovalid, n_ovalid;
    logic [IDX_W-1:0] r_oidx, n_oidx;
    logic signed [ACC_W-1:0] r_ox, n_ox, r_oy, n_oy, r_oz, n_oz;
    logic r_oclip, n_oclip, r_ofin, n_ofin;

    logic signed [2*DIFF_W-1:0] prod_sq [3];
    logic [WIDE_W-1:0] bitv, trial;
    logic [R2_W:0] shifted;
    logic ge;
    logic signed [DIFF_W-1:0] dk, adk;
    logic [WIDE_W-1:0] maddend;
    logic [WIDE_W-1:0] magc;
    logic signed [ACC_W+1:0] term, sum;
    logic clip;
    logic last;

    assign o_out.valid = r_ovalid;
    assign o_out.particle_index = r_oidx;
    assign o_out.accel_x = r_ox;
    assign o_out.accel_y = r_oy;
    assign o_out.accel_z = r_oz;
    assign o_out.clipped = r_oclip;
    assign o_out.final_result = r_ofin;

    always_ff @(posedge i_clk) begin
        r_n <= n_n; r_i <= n_i; r_j <= n_j; r_ovf <= n_ovf; r_k <= n_k; r_pi <= n_pi;
        r_d <= n_d; r_sq <= n_sq; r_r2 <= n_r2; r_den <= n_den; r_srem <= n_srem;
        r_res <= n_res; r_num <= n_num; r_prod <= n_prod; r_mag <= n_mag;
        r_drem <= n_drem; r_cnt <= n_cnt; r_div_t <= n_div_t; r_t <= n_t;
        r_acc <= n_acc; r_flag <= n_flag; r_oidx <= n_oidx; r_ox <= n_ox;
        r_oy <= n_oy; r_oz <= n_oz; r_oclip <= n_oclip; r_ofin <= n_ofin;
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        n_state = r_state; n_n = r_n; n_i = r_i; n_j = r_j; n_ovf = r_ovf; n_k = r_k;
        n_pi = r_pi; n_d = r_d; n_sq = r_sq; n_r2 = r_r2; n_den = r_den;
        n_srem = r_srem; n_res = r_res; n_num = r_num; n_prod = r_prod; n_mag = r_mag;
        n_drem = r_drem; n_cnt = r_cnt; n_div_t = r_div_t; n_t = r_t; n_acc = r_acc;
        n_flag = r_flag; n_oidx = r_oidx; n_ox = r_ox; n_oy = r_oy; n_oz = r_oz;
        n_oclip = r_oclip; n_ofin = r_ofin;
        n_ovalid = r_ovalid && !o_out.ready;
        o_job_pop = 1'b0;
        o_done = 1'b0;
        o_raddr = (r_state == ST_RD_I) ? r_i[AW-1:0] : r_j[AW-1:0];

        for (int q = 0; q < 3; q++) begin
            prod_sq[q] = r_d[q] * r_d[q];
        end
        bitv = WIDE_W'(1) << {r_cnt[4:0], 1'b0};
        trial = r_res + bitv;
        shifted = {r_drem[R2_W-1:0], r_num[WIDE_W-1]};
        ge = (shifted >= {1'b0, r_den});
        dk = r_d[r_k];
        adk = dk[DIFF_W-1] ? -dk : dk;
        maddend = adk[r_cnt[3:0]] ? WIDE_W'(r_t) : '0;
        magc = r_mag;
        clip = 1'b0;
        if (!dk[DIFF_W-1]) begin
            if (r_mag > WIDE_W'(64'h7FFF_FFFF)) begin
                magc = WIDE_W'(64'h7FFF_FFFF);
                clip = 1'b1;
            end
            term = (ACC_W+2)'({2'b00, magc[ACC_W-1:0]});
        end else begin
            if (r_mag > WIDE_W'(64'h8000_0000)) begin
                magc = WIDE_W'(64'h8000_0000);
                clip = 1'b1;
            end
            term = -(ACC_W+2)'({2'b00, magc[ACC_W-1:0]});
        end
        sum = (ACC_W+2)'(r_acc[r_k]) + term;
        last = (r_i + CNT_W'(1) == r_n);

        unique case (r_state)
            ST_IDLE: begin
                o_job_pop = 1'b1;
                if (i_job_valid) begin
                    n_n = i_job.count;
                    n_ovf = i_job.ovf;
                    n_i = '0;
                    n_state = ST_RD_I;
                end
            end
            ST_RD_I: n_state = ST_WT_I;
            ST_WT_I: begin
                n_pi = i_rdata;
                for (int q = 0; q < 3; q++) n_acc[q] = '0;
                n_flag = r_ovf;
                n_j = '0;
                n_state = ST_RD_J;
            end
            ST_RD_J: begin
                if (r_j == r_n) begin
                    n_state = ST_OUT;
                end else if (r_j == r_i) begin
                    n_j = r_j + CNT_W'(1);
                end else begin
                    n_state = ST_WT_J;
                end
            end
            ST_WT_J: begin
                for (int q = 0; q < 3; q++) begin
                    n_d[q] = $signed({1'b0, i_rdata[(2-q)*POS_W +: POS_W]})
                           - $signed({1'b0, r_pi[(2-q)*POS_W +: POS_W]});
                end
                n_state = ST_SQ;
            end
            ST_SQ: begin
                for (int q = 0; q < 3; q++) n_sq[q] = prod_sq[q][SQ_W-1:0];
                n_state = ST_R2;
            end
            ST_R2: begin
                n_r2 = R2_W'(r_sq[0]) + R2_W'(r_sq[1]) + R2_W'(r_sq[2]);
                n_state = ST_CHK;
            end
            ST_CHK: begin
                if (r_r2 == '0) begin
                    n_flag = 1'b1;
                    n_j = r_j + CNT_W'(1);
                    n_state = ST_RD_J;
                end else begin
                    n_srem = {2'b00, r_r2, {SQRT_SHIFT{1'b0}}};
                    n_res = '0;
                    n_cnt = 6'(SQRT_STEPS - 1);
                    n_state = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (r_srem >= trial) begin
                    n_srem = r_srem - trial;
                    n_res = (r_res >> 1) + bitv;
                end else begin
                    n_res = r_res >> 1;
                end
                if (r_cnt == '0) begin
                    n_num = WIDE_W'(1) << RECIP_EXP;
                    n_den = n_res[R2_W-1:0];
                    n_drem = '0;
                    n_cnt = 6'(WIDE_W - 1);
                    n_div_t = 1'b1;
                    n_state = ST_DIV;
                end else begin
                    n_cnt = r_cnt - 6'd1;
                end
            end
            ST_DIV: begin
                n_drem = ge ? shifted - {1'b0, r_den} : shifted;
                n_num = {r_num[WIDE_W-2:0], ge};
                if (r_cnt == '0) begin
                    if (r_div_t) begin
                        n_t = n_num[T_W-1:0];
                        n_k = '0;
                        n_prod = '0;
                        n_cnt = 6'(MUL_STEPS - 1);
                        n_state = ST_MUL;
                    end else begin
                        n_mag = n_num;
                        n_state = ST_ACC;
                    end
                end else begin
                    n_cnt = r_cnt - 6'd1;
                end
            end
            ST_MUL: begin
                n_prod = (r_prod << 1) + maddend;
                if (r_cnt == '0) begin
                    n_num = n_prod;
                    n_den = r_r2;
                    n_drem = '0;
                    n_cnt = 6'(WIDE_W - 1);
                    n_div_t = 1'b0;
                    n_state = ST_DIV;
                end else begin
                    n_cnt = r_cnt - 6'd1;
                end
            end
            ST_ACC: begin
                if (sum > (ACC_W+2)'(64'sh7FFF_FFFF)) begin
                    n_acc[r_k] = ACC_W'(32'sh7FFF_FFFF);
                    n_flag = 1'b1;
                end else if (sum < -(ACC_W+2)'(64'sh8000_0000)) begin
                    n_acc[r_k] = ACC_W'(32'sh8000_0000);
                    n_flag = 1'b1;
                end else begin
                    n_acc[r_k] = sum[ACC_W-1:0];
                end
                if (clip) n_flag = 1'b1;
                if (r_k == 2'd2) begin
                    n_j = r_j + CNT_W'(1);
                    n_state = ST_RD_J;
                end else begin
                    n_k = r_k + 2'd1;
                    n_prod = '0;
                    n_cnt = 6'(MUL_STEPS - 1);
                    n_state = ST_MUL;
                end
            end
            ST_OUT: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid = 1'b1;
                    n_oidx = r_i[IDX_W-1:0];
                    n_ox = r_acc[0];
                    n_oy = r_acc[1];
                    n_oz = r_acc[2];
                    n_oclip = r_flag;
                    n_ofin = last;
                    n_i = r_i + CNT_W'(1);
                    if (last) begin
                        o_done = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_RD_I;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

// ===== rtl/nbd_checker.sv =====
// Port-level checks of the gravity block, bound to its top level.
// Depends on the ports of nbody_direct_force_sum.
module nbd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       in_final,
    input logic       out_valid,
    input logic       out_ready,
    input logic [5:0] out_index,
    input logic       out_final
);
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !out_valid)
        else $error("output valid after reset");

    a_lock_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready && in_final |=> !in_ready)
        else $error("input taken while a set is computed");

    a_last_index_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_index == 6'd63 |-> out_final)
        else $error("index 63 not marked final");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_index) && $stable(out_final))
        else $error("stalled result changed");
endmodule

bind nbody_direct_force_sum nbd_checker u_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(i_in.valid), .in_ready(i_in.ready), .in_final(i_in.final_particle),
    .out_valid(o_out.valid), .out_ready(o_out.ready),
    .out_index(o_out.particle_index), .out_final(o_out.final_result)
);

// ===== sim/tb_nbody_direct_force_sum.sv =====
// Testbench for nbody_direct_force_sum: loads particle sets and checks every acceleration word.
// A local fixed-point predictor gives the expected words; idling and stalls vary by phase.
// Depends on nbd_pkg, nbd_if and the RTL of the block.
module tb_nbody_direct_force_sum;
    timeunit 1ns;
    timeprecision 1ps;
    import nbd_pkg::*;

    localparam int NPART = MAX_PARTICLES_DEF;
    localparam longint LIMIT = 6000000;
    localparam longint QMAX = 64'sd2147483647;
    localparam longint QMIN = -64'sd2147483648;

    typedef struct {
        logic [IDX_W-1:0] idx;
        logic [ACC_W-1:0] ax, ay, az;
        logic             clip;
        logic             last;
    } t_accel_word;

    typedef struct {
        logic [POS_W-1:0] x, y, z;
        logic             fin;
        bit               typed;
        bit               tclip;
    } t_load_row;

    logic i_clk;
    logic i_rst_n;
    nbd_in_if  in_ch();
    nbd_out_if out_ch();

    nbody_direct_force_sum dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    logic [POS_W-1:0] pos_mem[NPART][3];
    int               held_count;
    bit               dropped_seen;
    t_accel_word      accel_due[$];
    int               errors, words_checked, sets_sent, items_sent;
    int               send_idle_pct, recv_stall_pct;
    longint           cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles, %0d words pending", cycles, accel_due.size());
            $display("FAIL nbody_direct_force_sum");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) out_ch.ready <= 1'b0;
        else out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic report(input string what, input longint got, input longint want);
        errors++;
        $display("mismatch word %0d: %s got %0h want %0h", words_checked, what, got, want);
    endtask

    always @(negedge i_clk) begin
        t_accel_word e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (accel_due.size() == 0) begin
                report("unexpected word idx", out_ch.particle_index, 0);
            end else begin
                e = accel_due.pop_front();
                if (out_ch.particle_index !== e.idx) report("idx", out_ch.particle_index, e.idx);
                if (out_ch.accel_x !== e.ax) report("accel_x", out_ch.accel_x, e.ax);
                if (out_ch.accel_y !== e.ay) report("accel_y", out_ch.accel_y, e.ay);
                if (out_ch.accel_z !== e.az) report("accel_z", out_ch.accel_z, e.az);
                if (out_ch.clipped !== e.clip) report("clipped", out_ch.clipped, e.clip);
                if (out_ch.final_result !== e.last) report("final", out_ch.final_result, e.last);
            end
            words_checked++;
        end
    end

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned rem, res, b;
        rem = v;
        res = 0;
        b = 64'd1 << 62;
        while (b > rem) b >>= 2;
        while (b != 0) begin
            if (rem >= res + b) begin
                rem -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint add_pull(input longint acc, input longint d,
                                        input longint unsigned t, input longint unsigned r2,
                                        inout bit flg);
        longint unsigned mag;
        longint          term;
        mag = ((d < 0) ? -d : d) * t / r2;
        if (d >= 0) begin
            if (mag > QMAX) begin mag = QMAX; flg = 1; end
            term = mag;
        end else begin
            if (mag > 64'd2147483648) begin mag = 64'd2147483648; flg = 1; end
            term = -longint'(mag);
        end
        acc += term;
        if (acc > QMAX) begin acc = QMAX; flg = 1; end
        if (acc < QMIN) begin acc = QMIN; flg = 1; end
        return acc;
    endfunction

    // Update the store; on a final word return the acceleration of every held particle.
    task automatic load_position(input logic [POS_W-1:0] x, y, z, input logic fin,
                                 output t_accel_word res[$]);
        longint          acc[3], d[3];
        longint unsigned r2, s, t;
        bit              flg;
        t_accel_word     w;
        res = {};
        if (held_count < NPART) begin
            pos_mem[held_count][0] = x;
            pos_mem[held_count][1] = y;
            pos_mem[held_count][2] = z;
            held_count++;
        end else begin
            dropped_seen = 1;
        end
        if (!fin) return;
        for (int i = 0; i < held_count; i++) begin
            acc = '{0, 0, 0};
            flg = dropped_seen;
            for (int j = 0; j < held_count; j++) begin
                if (i == j) continue;
                r2 = 0;
                for (int k = 0; k < 3; k++) begin
                    d[k] = longint'(pos_mem[j][k]) - longint'(pos_mem[i][k]);
                    r2 += d[k] * d[k];
                end
                if (r2 == 0) begin
                    flg = 1;
                    continue;
                end
                s = int_sqrt(r2 << SQRT_SHIFT);
                t = (64'd1 << RECIP_EXP) / s;
                for (int k = 0; k < 3; k++) acc[k] = add_pull(acc[k], d[k], t, r2, flg);
            end
            w.idx = i[IDX_W-1:0];
            w.ax = acc[0][31:0];
            w.ay = acc[1][31:0];
            w.az = acc[2][31:0];
            w.clip = flg;
            w.last = (i + 1 == held_count);
            res = {res, w};
        end
        held_count = 0;
        dropped_seen = 0;
    endtask

    task automatic send_word(input logic [POS_W-1:0] x, y, z, input logic fin,
                             input bit typed, input bit tclip);
        t_accel_word res[$];
        bit          taken;
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.pos_x <= x;
        in_ch.pos_y <= y;
        in_ch.pos_z <= z;
        in_ch.final_particle <= fin;
        taken = 0;
        while (!taken) begin
            @(negedge i_clk);
            taken = in_ch.ready;
            @(posedge i_clk);
        end
        items_sent++;
        load_position(x, y, z, fin, res);
        foreach (res[k]) begin
            if (typed) begin
                res[k].ax = '0;
                res[k].ay = '0;
                res[k].az = '0;
                res[k].clip = tclip;
            end
            accel_due = {accel_due, res[k]};
        end
        if (fin) sets_sent++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (accel_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [POS_W-1:0] rand_pos(input logic [POS_W-1:0] base, input int mode);
        unique case (mode)
            0: return POS_W'($urandom);
            1: return base + POS_W'($urandom_range(3)) - 16'd1;
            default: return base;
        endcase
    endfunction

    t_load_row table_rows[] = '{
        '{16'h0000, 16'h0000, 16'h0000, 1'b1, 1, 0},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1, 0},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1, 1},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1, 1},
        '{16'h0000, 16'h0000, 16'h0000, 1'b0, 0, 0},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 0, 0},
        '{16'h0000, 16'h0000, 16'h0000, 1'b0, 0, 0},
        '{16'h0001, 16'h0000, 16'h0000, 1'b1, 0, 0},
        '{16'h8000, 16'h8000, 16'h8000, 1'b0, 0, 0},
        '{16'h8001, 16'h8000, 16'h8000, 1'b0, 0, 0},
        '{16'h8001, 16'h8001, 16'h8000, 1'b1, 0, 0},
        '{16'h1234, 16'hFEDC, 16'h0F0F, 1'b0, 0, 0},
        '{16'h1234, 16'hFEDC, 16'h0F0F, 1'b0, 0, 0},
        '{16'hA5A5, 16'h5A5A, 16'h00FF, 1'b1, 0, 0},
        '{16'h0000, 16'hFFFF, 16'h0000, 1'b0, 0, 0},
        '{16'hFFFF, 16'h0000, 16'hFFFF, 1'b0, 0, 0},
        '{16'h0000, 16'h0000, 16'hFFFF, 1'b0, 0, 0},
        '{16'h7FFF, 16'h8000, 16'h7FFF, 1'b1, 0, 0}
    };

    initial begin
        logic [POS_W-1:0] bx, by, bz;
        int               n, mode;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.pos_x = '0;
        in_ch.pos_y = '0;
        in_ch.pos_z = '0;
        in_ch.final_particle = 1'b0;
        out_ch.ready = 1'b0;
        cycles = 0;
        errors = 0;
        words_checked = 0;
        sets_sent = 0;
        items_sent = 0;
        held_count = 0;
        dropped_seen = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (table_rows[r])
            send_word(table_rows[r].x, table_rows[r].y, table_rows[r].z, table_rows[r].fin,
                      table_rows[r].typed, table_rows[r].tclip);

        // full store plus dropped words; mostly coincident to keep the pair count cheap
        send_idle_pct = 8;
        recv_stall_pct = 8;
        for (int p = 0; p < NPART + 3; p++) begin
            if (p == 5) send_word(16'h0100, 16'hFFFF, 16'h0000, 1'b0, 0, 0);
            else if (p == 40) send_word(16'hFF00, 16'h0000, 16'hFFFF, 1'b0, 0, 0);
            else send_word(16'h4000, 16'h4000, 16'h4000, p == NPART + 2, 0, 0);
        end
        drain();

        while (items_sent < 500) begin
            unique case (sets_sent % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            if ($urandom_range(9) == 0) drain();
            n = ($urandom_range(15) == 0) ? $urandom_range(6, 10) : $urandom_range(1, 5);
            bx = POS_W'($urandom);
            by = POS_W'($urandom);
            bz = POS_W'($urandom);
            for (int p = 0; p < n; p++) begin
                mode = $urandom_range(9);
                mode = (mode < 7) ? 0 : (mode < 9) ? 1 : 2;
                send_word(rand_pos(bx, mode), rand_pos(by, mode), rand_pos(bz, mode),
                          p == n - 1, 0, 0);
            end
        end

        drain();
        repeat (50) @(posedge i_clk);
        $display("covered %0d position words in %0d sets, %0d acceleration words checked",
                 items_sent, sets_sent, words_checked);
        $display("includes a full store with dropped words, coincident and saturating pairs");
        if (errors == 0 && accel_due.size() == 0) begin
            $display("PASS nbody_direct_force_sum");
        end else begin
            $display("%0d mismatches, %0d words never arrived", errors, accel_due.size());
            $display("FAIL nbody_direct_force_sum");
        end
        $finish;
    end

endmodule
